// ===== design/sdcs_pkg.sv =====
// Package for the SD SPI command sender: item and job types, constants,
// and the CRC7 byte update. Used by every module of the block.
`timescale 1ns / 1ps

package sdcs_pkg;

  localparam logic [7:0] IdleByte       = 8'hFF;
  localparam logic [7:0] CmdStartBits   = 8'h40;
  localparam logic [6:0] CrcPoly        = 7'h09;
  localparam logic [7:0] PollLimitReset = 8'd128;
  localparam int         QueueDepth     = 2;
  localparam int         QueuePtrW      = $clog2(QueueDepth);
  localparam int         QueueCntW      = $clog2(QueueDepth + 1);

  // Position of each frame byte in a command's result sequence
  localparam logic [2:0] StepIdle  = 3'd0;
  localparam logic [2:0] StepIndex = 3'd1;
  localparam logic [2:0] StepArg3  = 3'd2;
  localparam logic [2:0] StepArg2  = 3'd3;
  localparam logic [2:0] StepArg1  = 3'd4;
  localparam logic [2:0] StepArg0  = 3'd5;
  localparam logic [2:0] StepCrc   = 3'd6;
  localparam logic [2:0] StepLast  = 3'd7;

  typedef enum logic {
    KindCommand  = 1'b0,
    KindReceived = 1'b1
  } in_kind_e;

  typedef enum logic [1:0] {
    JobCmd    = 2'd0,
    JobPoll   = 2'd1,
    JobFinish = 2'd2
  } job_kind_e;

  typedef struct packed {
    logic        kind;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [7:0]  received_byte;
  } in_item_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       card_select;
    logic       finished;
    logic [7:0] response;
    logic       timed_out;
    logic       last;
  } out_item_t;

  // Work handed from the front to the back through the queue
  typedef struct packed {
    job_kind_e   kind;
    logic [5:0]  command_index;
    logic [31:0] argument;
    logic [7:0]  response;
    logic        timed_out;
    logic        no_poll;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_push_t;

  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in,
                                           input logic [7:0] data_in);
    logic [6:0] crc;
    logic [7:0] data;
    logic       top;
    crc  = crc_in;
    data = data_in;
    for (int i = 0; i < 8; i++) begin
      top  = data[7] ^ crc[6];
      crc  = {crc[5:0], 1'b0} ^ (top ? CrcPoly : 7'h00);
      data = {data[6:0], 1'b0};
    end
    return crc;
  endfunction

endpackage

// ===== design/sdcs_front.sv =====
// Front end of the SD SPI command sender: accepts items, tracks the
// response wait and poll budget, and turns commands, and bytes
// received during a response wait, into jobs. Depends on sdcs_pkg.
`timescale 1ns / 1ps

module sdcs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sdcs_pkg::in_item_t in_data_i,
  input  logic [7:0]         poll_limit_i,
  input  logic               queue_full_i,
  output sdcs_pkg::job_push_t push_o
);
  import sdcs_pkg::*;

  logic       awaiting_q, awaiting_d;
  logic [7:0] polls_q, polls_d;
  logic       accept;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  always_comb begin
    awaiting_d                = awaiting_q;
    polls_d                   = polls_q;
    push_o.valid              = 1'b0;
    push_o.job.kind           = JobCmd;
    push_o.job.command_index  = in_data_i.command_index;
    push_o.job.argument       = in_data_i.argument;
    push_o.job.response       = IdleByte;
    push_o.job.timed_out      = 1'b0;
    push_o.job.no_poll        = (poll_limit_i == 8'd0);
    if (accept) begin
      if (in_data_i.kind == KindCommand) begin
        // a new command drops any pending exchange
        push_o.valid = 1'b1;
        awaiting_d   = (poll_limit_i != 8'd0);
        polls_d      = (poll_limit_i != 8'd0) ? poll_limit_i - 8'd1 : 8'd0;
      end else if (awaiting_q) begin
        push_o.valid = 1'b1;
        if (in_data_i.received_byte != IdleByte) begin
          push_o.job.kind     = JobFinish;
          push_o.job.response = in_data_i.received_byte;
          awaiting_d          = 1'b0;
          polls_d             = 8'd0;
        end else if (polls_q != 8'd0) begin
          push_o.job.kind = JobPoll;
          polls_d         = polls_q - 8'd1;
        end else begin
          push_o.job.kind      = JobFinish;
          push_o.job.timed_out = 1'b1;
          awaiting_d           = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaiting_q <= 1'b0;
      polls_q    <= 8'd0;
    end else begin
      awaiting_q <= awaiting_d;
      polls_q    <= polls_d;
    end
  end

endmodule

// ===== design/sdcs_queue.sv =====
// Short job queue between front and back of the SD SPI command sender.
// Depends on sdcs_pkg.
`timescale 1ns / 1ps

module sdcs_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdcs_pkg::job_push_t push_i,
  output logic                full_o,
  output logic                head_valid_o,
  output sdcs_pkg::job_t      head_o,
  input  logic                pop_i
);
  import sdcs_pkg::*;

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o       = (cnt_q == QueueCntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QueueCntW'(do_push) - QueueCntW'(do_pop);
    end
  end

endmodule

// ===== design/sdcs_back.sv =====
// Back end of the SD SPI command sender: plays out each job as result
// items into an output register, running CRC7 one frame byte per cycle
// while the output is not stalled. Depends on sdcs_pkg.
`timescale 1ns / 1ps

module sdcs_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  sdcs_pkg::job_t      head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdcs_pkg::out_item_t out_data_o
);
  import sdcs_pkg::*;

  logic [2:0] step_q, step_d;
  logic [6:0] crc_q, crc_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;
  logic       slot_free, emit;
  logic [7:0] frame_byte;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign emit        = head_valid_i && slot_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    case (step_q)
      StepIdle:  frame_byte = IdleByte;
      StepIndex: frame_byte = CmdStartBits | {2'b00, head_i.command_index};
      StepArg3:  frame_byte = head_i.argument[31:24];
      StepArg2:  frame_byte = head_i.argument[23:16];
      StepArg1:  frame_byte = head_i.argument[15:8];
      StepArg0:  frame_byte = head_i.argument[7:0];
      StepCrc:   frame_byte = {crc_q, 1'b1};
      default:   frame_byte = IdleByte;
    endcase
  end

  always_comb begin
    step_d      = step_q;
    crc_d       = crc_q;
    pop_o       = 1'b0;
    out_valid_d = slot_free ? 1'b0 : out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d       = 1'b1;
      out_d.send_valid  = 1'b1;
      out_d.send_byte   = IdleByte;
      out_d.card_select = 1'b1;
      out_d.finished    = 1'b0;
      out_d.response    = 8'd0;
      out_d.timed_out   = 1'b0;
      out_d.last        = 1'b1;
      case (head_i.kind)
        JobCmd: begin
          if (step_q == StepLast) begin
            pop_o  = 1'b1;
            step_d = StepIdle;
            if (head_i.no_poll) begin
              out_d.send_valid  = 1'b0;
              out_d.send_byte   = 8'd0;
              out_d.card_select = 1'b0;
              out_d.finished    = 1'b1;
              out_d.response    = IdleByte;
              out_d.timed_out   = 1'b1;
            end
          end else begin
            out_d.send_byte = frame_byte;
            out_d.last      = 1'b0;
            step_d          = step_q + 3'd1;
            // fold the five command bytes into the CRC as they go out
            if (step_q == StepIdle) begin
              crc_d = 7'd0;
            end else if (step_q != StepCrc) begin
              crc_d = crc7_byte(crc_q, frame_byte);
            end
          end
        end
        JobPoll: begin
          pop_o = 1'b1;
        end
        JobFinish: begin
          pop_o             = 1'b1;
          out_d.send_valid  = 1'b0;
          out_d.send_byte   = 8'd0;
          out_d.card_select = 1'b0;
          out_d.finished    = 1'b1;
          out_d.response    = head_i.response;
          out_d.timed_out   = head_i.timed_out;
        end
        default: begin
          pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepIdle;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    crc_q <= crc_d;
    out_q <= out_d;
  end

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("pop without a queued job");

  a_step_in_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != StepIdle |-> head_valid_i && head_i.kind == JobCmd)
    else $error("frame step advanced outside a command");

  a_frame_keeps_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last |-> out_q.card_select && out_q.send_valid)
    else $error("frame byte without chip select");

  a_finish_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.finished |-> out_q.last && !out_q.card_select)
    else $error("finishing item not last or select held");

  a_command_pops_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && head_i.kind == JobCmd |-> step_q == StepLast)
    else $error("command left the queue before its last byte");

endmodule

// ===== design/sd_spi_command_sender_core.sv =====
// SD card SPI command sender: top level joining front end, job queue and
// back end. Depends on sdcs_pkg, sdcs_front, sdcs_queue and sdcs_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes either a
//   command (kind 0: index and 32-bit argument) or a byte received from
//   the card (kind 1). Output channel (out_valid_o / out_stall_i /
//   out_data_o) gives one item per line event; last marks the final item
//   caused by an input.
//   A command yields eight items: 0xFF, 0x40|index, four argument bytes,
//   the CRC7 byte, then a 0xFF poll or, with a zero poll limit, a timeout
//   finish. A received byte yields one item (poll or finish), or none
//   when no response is awaited.
//   An accepted input is written into the job queue; its first item is
//   then registered in the output register. The back end gives one output
//   item per cycle unless the output stalls; the two-entry job queue lets
//   the front accept while the back end is busy.
//   cfg_we_i / cfg_wdata_i set the poll limit (reset 128); write it only
//   while the block is idle.
//   Reset empties the queue and clears the output valid and wait state.
//   A stall on the output holds the current item and, once the queue
//   fills, raises in_stall_o.
`timescale 1ns / 1ps

module sd_spi_command_sender_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sdcs_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sdcs_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);
  import sdcs_pkg::*;

  logic [7:0] poll_limit_q;
  job_push_t  push;
  logic       queue_full;
  logic       head_valid;
  job_t       head;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_limit_q <= PollLimitReset;
    end else if (cfg_we_i) begin
      poll_limit_q <= cfg_wdata_i;
    end
  end

  sdcs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .poll_limit_i (poll_limit_q),
    .queue_full_i (queue_full),
    .push_o       (push)
  );

  sdcs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (queue_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  sdcs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule
